/* hdl/wfts_pkg.sv */
// Shared types, constants and command codes for the weighted fair task scheduler.
// No dependencies; every other file of the block but wfts_ram imports this package.
`timescale 1ns / 1ps

package wfts_pkg;

    localparam int SLOTS  = 256;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CUR_W  = SLOT_W + 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int TIME_W = 48;
    localparam int VR_W   = 64;
    localparam int WT_W   = 12;
    localparam int ID_W   = 16;
    localparam int TICK_W = 32;
    localparam int SHIFT  = 10;
    localparam int DIVD_W = TIME_W + SHIFT;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_CREATE = 2'd1;
    localparam logic [1:0] ACT_EXIT   = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NOFREE  = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    localparam logic [2:0] PRI_HIGH = 3'd1;
    localparam logic [2:0] PRI_LOW  = 3'd3;

    localparam logic [WT_W-1:0] W_NORMAL = 12'd1024;
    localparam logic [WT_W-1:0] W_HIGH   = 12'd3121;
    localparam logic [WT_W-1:0] W_LOW    = 12'd335;

    localparam logic [7:0] SLICE_RST = 8'd10;

    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_TICK      = 4'd2;
    localparam logic [3:0] OP_INIT      = 4'd3;
    localparam logic [3:0] OP_FREE      = 4'd4;
    localparam logic [3:0] OP_CREATE    = 4'd5;
    localparam logic [3:0] OP_NOFREE    = 4'd6;
    localparam logic [3:0] OP_IGNORE    = 4'd7;
    localparam logic [3:0] OP_EXIT      = 4'd8;
    localparam logic [3:0] OP_PICK      = 4'd9;
    localparam logic [3:0] OP_RD_PREV   = 4'd10;
    localparam logic [3:0] OP_CHG_START = 4'd11;
    localparam logic [3:0] OP_CHG_WR    = 4'd12;
    localparam logic [3:0] OP_RD_NEXT   = 4'd13;
    localparam logic [3:0] OP_SWITCH    = 4'd14;
    localparam logic [3:0] OP_EMIT      = 4'd15;

    typedef struct packed {
        logic [VR_W-1:0]   vr;
        logic [WT_W-1:0]   weight;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] start;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       cur_task_ok;
        logic       div_busy;
        logic       rem_zero;
        logic       free_hit;
        logic       scan_end;
        logic       pick_done;
        logic       same;
        logic       can_charge;
        logic       out_free;
    } t_sts;

endpackage

/* hdl/weighted_fair_task_scheduler_unit.sv */
// Top level of the weighted fair task scheduler: controller plus datapath.
// Depends on wfts_pkg, wfts_ctrl and wfts_dp (which holds wfts_ram and wfts_div).
`timescale 1ns / 1ps

// Weighted fair task scheduler over a table of 256 task slots, slot 0 being the
// idle task. Each input transfer is one event (tick, create, exit) stamped with
// the current time, and each event yields exactly one result transfer carrying
// the status, the id of a created task, the running slot and id, a switch flag
// and the run queue depth. Events are handled one at a time. Every tick runs
// its tick period check through the bit-serial divider, one bit per cycle over
// 58 bits. A create scans upward from slot 1 for the lowest free slot. A
// reschedule scans every task slot but idle slot 0 through the single RAM read
// port, one entry per cycle, and charging the outgoing task adds one divider
// pass. The result sits in an output register, so the next event is taken
// while that result waits; the block stalls only when a second result is
// ready before the first is taken. No clearing pass follows reset: table
// entries are written before any event uses them. The user must write the
// slice_ticks register through its own transfer channel only while the block
// idles; the block itself does not enforce this. Zero acts as one.
module weighted_fair_task_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_priority_req,
    input  logic [47:0] i_time_now,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_new_task_id,
    output logic [7:0]  o_running_slot,
    output logic [15:0] o_running_id,
    output logic        o_switched,
    output logic [8:0]  o_ready_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_slice_ticks
);
    import wfts_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Accept configuration at any time; writes must arrive only while idle, which the block itself does not enforce.
    assign o_cfg_ready = 1'b1;

    // Sequence each event through decode and, as the event needs, scan, charge and switch steps.
    wfts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Hold the task table, queue flags, arithmetic and the result register.
    wfts_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_slice_ticks (i_cfg_slice_ticks),
        .i_action          (i_action),
        .i_priority_req    (i_priority_req),
        .i_time_now        (i_time_now),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_new_task_id     (o_new_task_id),
        .o_running_slot    (o_running_slot),
        .o_running_id      (o_running_id),
        .o_switched        (o_switched),
        .o_ready_count     (o_ready_count)
    );

`ifndef NO_ASSERTIONS
    // No event is taken while the divider is still working on the last one.
    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_sts.div_busy)
        else $error("input ready while divider busy");

    // Idle never runs with a task id other than zero.
    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_running_slot == 8'd0) |-> (o_running_id == 16'd0))
        else $error("idle slot reported with nonzero id");

    // The running task is never in the queue, so at most SLOTS-1 wait.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ready_count <= 9'(SLOTS - 1)))
        else $error("ready count out of range");

    // A switch always reports a completed event.
    a_switch_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_switched |-> (o_status == STAT_DONE))
        else $error("switch reported with error status");
`endif

endmodule

/* hdl/wfts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wfts_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/wfts_div.sv */
// Restoring divider, one quotient bit per cycle, for charge and tick period.
// Depends on wfts_pkg.
`timescale 1ns / 1ps

module wfts_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wfts_pkg::DIVD_W-1:0] i_dividend,
    input  logic [wfts_pkg::WT_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic [wfts_pkg::DIVD_W-1:0] o_quotient,
    output logic [wfts_pkg::WT_W-1:0]   o_remainder
);
    import wfts_pkg::*;

    localparam int CNT_DW = $clog2(DIVD_W);

    logic              r_busy;
    logic [CNT_DW-1:0] r_cnt;
    logic [WT_W-1:0]   r_rem;
    logic [WT_W-1:0]   r_d;
    logic [DIVD_W-1:0] r_quo;
    logic [WT_W:0]     rem_sh;
    logic [WT_W:0]     diff;
    logic              ge;

    assign rem_sh = {r_rem, r_quo[DIVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_d};
    assign diff   = rem_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_d    <= i_divisor;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[WT_W-1:0] : rem_sh[WT_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_DW'(DIVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* hdl/wfts_ctrl.sv */
// Sequencing state machine: decodes an event and steps the datapath.
// Depends on wfts_pkg.
`timescale 1ns / 1ps

module wfts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wfts_pkg::t_sts i_sts,
    output wfts_pkg::t_cmd o_cmd
);
    import wfts_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_TDIV   = 4'd2;
    localparam logic [3:0] S_FREE   = 4'd3;
    localparam logic [3:0] S_PICK   = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_CDIV   = 4'd6;
    localparam logic [3:0] S_CWAIT  = 4'd7;
    localparam logic [3:0] S_RDNX   = 4'd8;
    localparam logic [3:0] S_SWITCH = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [3:0] op;

    always_comb begin
        n_state = r_state;
        op      = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.action)
                    ACT_TICK: begin
                        op      = OP_TICK;
                        n_state = S_TDIV;
                    end
                    ACT_CREATE: begin
                        op      = OP_INIT;
                        n_state = S_FREE;
                    end
                    ACT_EXIT: begin
                        if (i_sts.cur_task_ok) begin
                            op      = OP_EXIT;
                            n_state = S_PICK;
                        end else begin
                            op      = OP_IGNORE;
                            n_state = S_EMIT;
                        end
                    end
                    default: begin
                        op      = OP_IGNORE;
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_TDIV: begin
                if (!i_sts.div_busy) begin
                    if (i_sts.rem_zero) begin
                        op      = OP_INIT;
                        n_state = S_PICK;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_FREE: begin
                priority if (i_sts.free_hit) begin
                    op      = OP_CREATE;
                    n_state = S_EMIT;
                end else if (i_sts.scan_end) begin
                    op      = OP_NOFREE;
                    n_state = S_EMIT;
                end else begin
                    op = OP_FREE;
                end
            end
            S_PICK: begin
                op = OP_PICK;
                if (i_sts.pick_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (i_sts.same) begin
                    n_state = S_EMIT;
                end else if (i_sts.can_charge) begin
                    op      = OP_RD_PREV;
                    n_state = S_CDIV;
                end else begin
                    op      = OP_RD_NEXT;
                    n_state = S_SWITCH;
                end
            end
            S_CDIV: begin
                op      = OP_CHG_START;
                n_state = S_CWAIT;
            end
            S_CWAIT: begin
                if (!i_sts.div_busy) begin
                    op      = OP_CHG_WR;
                    n_state = S_RDNX;
                end
            end
            S_RDNX: begin
                op      = OP_RD_NEXT;
                n_state = S_SWITCH;
            end
            S_SWITCH: begin
                op      = OP_SWITCH;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    op      = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.op   = op;

endmodule

/* hdl/wfts_dp.sv */
// Datapath: task table, run queue flags, scan counters, charge arithmetic, result register.
// Depends on wfts_pkg, wfts_ram and wfts_div.
`timescale 1ns / 1ps

module wfts_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wfts_pkg::t_cmd              i_cmd,
    output wfts_pkg::t_sts              o_sts,
    input  logic                        i_cfg_we,
    input  logic [7:0]                  i_cfg_slice_ticks,
    input  logic [1:0]                  i_action,
    input  logic [2:0]                  i_priority_req,
    input  logic [wfts_pkg::TIME_W-1:0] i_time_now,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [15:0]                 o_new_task_id,
    output logic [7:0]                  o_running_slot,
    output logic [15:0]                 o_running_id,
    output logic                        o_switched,
    output logic [8:0]                  o_ready_count
);
    import wfts_pkg::*;

    logic [1:0]        r_action;
    logic [2:0]        r_prio;
    logic [TIME_W-1:0] r_now;
    logic [7:0]        r_slice;
    logic [TICK_W-1:0] r_tick;
    logic [ID_W-1:0]   r_next_id;
    logic [VR_W-1:0]   r_floor;
    logic              r_used   [SLOTS];
    logic              r_queued [SLOTS];
    logic [CNT_W-1:0]  r_count;
    logic [CUR_W-1:0]  r_cur;
    logic [ID_W-1:0]   r_cur_id;
    logic [CUR_W-1:0]  r_idx;
    logic              r_found;
    logic [SLOT_W-1:0] r_best;
    logic [VR_W-1:0]   r_best_vr;
    logic              r_pv;
    logic [SLOT_W-1:0] r_pslot;
    logic              r_pq;
    logic              r_exiting;
    logic              r_req;
    logic [VR_W-1:0]   r_prev_vr;
    logic [1:0]        r_status;
    logic [ID_W-1:0]   r_made;
    logic              r_sw;
    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic [15:0]       r_o_made;
    logic [7:0]        r_o_slot;
    logic [15:0]       r_o_id;
    logic              r_o_sw;
    logic [8:0]        r_o_count;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    t_entry            ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    t_entry            q;

    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [WT_W-1:0]   div_divisor;
    logic              div_busy;
    logic [DIVD_W-1:0] div_quo;
    logic [WT_W-1:0]   div_rem;

    logic [7:0]        period;
    logic [TICK_W-1:0] tick_inc;
    logic [TIME_W-1:0] elapsed;
    logic [VR_W:0]     sum;
    logic [VR_W-1:0]   new_vr;
    logic [CUR_W-1:0]  next_slot;
    logic [VR_W-1:0]   least;
    logic [WT_W-1:0]   weight;
    logic              idx_in;
    logic              cur_ok;

    assign period    = (r_slice == 8'd0) ? 8'd1 : r_slice;
    assign tick_inc  = r_tick + 1'b1;
    assign elapsed   = (r_now >= q.start) ? (r_now - q.start) : '0;
    assign sum       = {1'b0, q.vr} + (VR_W + 1)'(div_quo);
    assign new_vr    = sum[VR_W] ? '1 : sum[VR_W-1:0];
    assign next_slot = r_found ? {1'b0, r_best} : '0;
    assign idx_in    = r_idx < CUR_W'(SLOTS);
    assign cur_ok    = (r_cur != '0) && (r_cur < CUR_W'(SLOTS));
    assign least     = (r_req && (r_prev_vr < r_best_vr)) ? r_prev_vr : r_best_vr;
    assign weight    = (r_prio == PRI_HIGH) ? W_HIGH :
                       (r_prio == PRI_LOW)  ? W_LOW  : W_NORMAL;

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_idx[SLOT_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_best;
        ram_wdata = q;
        unique case (i_cmd.op)
            OP_PICK: begin
                ram_re = idx_in;
            end
            OP_RD_PREV: begin
                ram_re    = 1'b1;
                ram_raddr = r_cur[SLOT_W-1:0];
            end
            OP_RD_NEXT: begin
                ram_re    = r_found;
                ram_raddr = r_best;
            end
            OP_CREATE: begin
                ram_we           = 1'b1;
                ram_wdata.vr     = r_floor;
                ram_wdata.weight = weight;
                ram_wdata.id     = r_next_id;
                ram_wdata.start  = '0;
            end
            OP_CHG_WR: begin
                ram_we       = 1'b1;
                ram_waddr    = r_cur[SLOT_W-1:0];
                ram_wdata.vr = new_vr;
            end
            OP_SWITCH: begin
                ram_we          = r_found;
                ram_wdata.start = r_now;
            end
            default: begin
            end
        endcase
    end

    assign div_start    = (i_cmd.op == OP_TICK) || (i_cmd.op == OP_CHG_START);
    assign div_dividend = (i_cmd.op == OP_TICK) ? DIVD_W'(tick_inc) : {elapsed, SHIFT'(0)};
    assign div_divisor  = (i_cmd.op == OP_TICK) ? WT_W'(period) : q.weight;

    wfts_ram #(.W(ENTRY_W), .D(SLOTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (q)
    );

    wfts_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        if (r_pv && r_pq && (!r_found || (q.vr < r_best_vr))) begin
            r_best    <= r_pslot;
            r_best_vr <= q.vr;
        end
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_action <= i_action;
                r_prio   <= i_priority_req;
                r_now    <= i_time_now;
                r_made   <= '0;
            end
            OP_FREE: begin
                if (!r_used[r_idx[SLOT_W-1:0]]) begin
                    r_best <= r_idx[SLOT_W-1:0];
                end
            end
            OP_PICK: begin
                r_pslot <= r_idx[SLOT_W-1:0];
                r_pq    <= r_queued[r_idx[SLOT_W-1:0]];
            end
            OP_CREATE: begin
                r_made <= r_next_id;
            end
            OP_CHG_WR: begin
                r_prev_vr <= new_vr;
            end
            OP_EMIT: begin
                r_o_status <= r_status;
                r_o_made   <= 16'(r_made);
                r_o_slot   <= cur_ok ? 8'(r_cur[SLOT_W-1:0]) : 8'd0;
                r_o_id     <= 16'(r_cur_id);
                r_o_sw     <= r_sw;
                r_o_count  <= 9'(r_count);
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice     <= SLICE_RST;
            r_tick      <= '0;
            r_next_id   <= ID_W'(1);
            r_floor     <= '0;
            r_count     <= '0;
            r_cur       <= CUR_W'(SLOTS);
            r_cur_id    <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_pv        <= 1'b0;
            r_exiting   <= 1'b0;
            r_req       <= 1'b0;
            r_status    <= STAT_DONE;
            r_sw        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_used[i]   <= (i == 0);
                r_queued[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_slice <= i_cfg_slice_ticks;
            end
            if (r_pv && r_pq && (!r_found || (q.vr < r_best_vr))) begin
                r_found <= 1'b1;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_status  <= STAT_DONE;
                    r_sw      <= 1'b0;
                    r_exiting <= 1'b0;
                    r_req     <= 1'b0;
                end
                OP_TICK: begin
                    r_tick <= tick_inc;
                end
                OP_INIT, OP_EXIT: begin
                    r_idx     <= CUR_W'(1);
                    r_found   <= 1'b0;
                    r_pv      <= 1'b0;
                    r_exiting <= (i_cmd.op == OP_EXIT);
                end
                OP_FREE: begin
                    if (!r_used[r_idx[SLOT_W-1:0]]) begin
                        r_found <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                OP_PICK: begin
                    r_pv <= idx_in;
                    if (idx_in) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                OP_CREATE: begin
                    r_used[r_best]   <= 1'b1;
                    r_queued[r_best] <= 1'b1;
                    r_count          <= r_count + 1'b1;
                    r_next_id        <= r_next_id + 1'b1;
                end
                OP_NOFREE: begin
                    r_status <= STAT_NOFREE;
                end
                OP_IGNORE: begin
                    r_status <= STAT_IGNORED;
                end
                OP_CHG_WR: begin
                    r_queued[r_cur[SLOT_W-1:0]] <= 1'b1;
                    r_count                     <= r_count + 1'b1;
                    r_req                       <= 1'b1;
                end
                OP_SWITCH: begin
                    if (r_found) begin
                        r_queued[r_best] <= 1'b0;
                        r_count          <= r_count - 1'b1;
                        if (least > r_floor) begin
                            r_floor <= least;
                        end
                    end
                    r_cur    <= next_slot;
                    r_cur_id <= r_found ? q.id : '0;
                    r_sw     <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.action      = r_action;
    assign o_sts.cur_task_ok = cur_ok;
    assign o_sts.div_busy    = div_busy;
    assign o_sts.rem_zero    = (div_rem == '0);
    assign o_sts.free_hit    = r_found;
    assign o_sts.scan_end    = !idx_in;
    assign o_sts.pick_done   = !idx_in && !r_pv;
    assign o_sts.same        = (next_slot == r_cur);
    assign o_sts.can_charge  = cur_ok && !r_exiting;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_new_task_id  = r_o_made;
    assign o_running_slot = r_o_slot;
    assign o_running_id   = r_o_id;
    assign o_switched     = r_o_sw;
    assign o_ready_count  = r_o_count;

endmodule
